@@ hdl/btafd_pkg.sv @@
// ----------------------------------------------------------------------------
// btafd_pkg
// Shared types and constants of the BCD time and angle frame decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package btafd_pkg;

  // frame bytes 1..16 are the only ones that feed the decode
  localparam int unsigned FrameBytes = 16;
  localparam int unsigned FrameIdxW  = $clog2(FrameBytes);
  localparam int unsigned PosW       = 5;

  localparam logic [PosW-1:0] PosHunt     = 5'd0;
  localparam logic [PosW-1:0] PosFirst    = 5'd1;
  localparam logic [PosW-1:0] PosStoreEnd = 5'd16;
  localparam logic [PosW-1:0] PosLast     = 5'd19;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_START_BYTE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_END_BYTE   = 2'd1;

  localparam logic [7:0] StartByteRst = 8'h7E;
  localparam logic [7:0] EndByteRst   = 8'hE7;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_AZIMUTH   = 2'd0,
    KIND_ELEVATION = 2'd1,
    KIND_LINK_OK   = 2'd2,
    KIND_LINK_LOST = 2'd3
  } kind_e;

  typedef struct packed {
    logic                       tick;
    logic                       link_ok;
    logic [FrameBytes-1:0][7:0] frame;
  } job_t;

endpackage

`default_nettype wire

@@ hdl/btafd_front.sv @@
// ----------------------------------------------------------------------------
// btafd_front
// Byte framing, tick handling and configuration registers; queues jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btafd_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           opcode_i,
  input  wire logic [7:0]                     rx_byte_i,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [btafd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [7:0]                     cfg_data_i,
  output logic                                push_o,
  output btafd_pkg::job_t                     push_job_o,
  input  wire logic                           full_i
);
  import btafd_pkg::*;

  logic [PosW-1:0]            pos_q, pos_d;
  logic                       seen_q, seen_d;
  logic [7:0]                 start_q, end_q;
  logic [FrameBytes-1:0][7:0] frame_q;
  logic                       store_we;
  logic [FrameIdxW-1:0]       wr_idx;
  logic                       accept;

  assign in_ready_o  = !full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign wr_idx      = FrameIdxW'(pos_q - PosFirst);

  always_comb begin
    pos_d              = pos_q;
    seen_d             = seen_q;
    store_we           = 1'b0;
    push_o             = 1'b0;
    push_job_o.tick    = 1'b0;
    push_job_o.link_ok = seen_q;
    push_job_o.frame   = frame_q;
    if (accept) begin
      if (opcode_i == OP_TICK) begin
        push_o          = 1'b1;
        push_job_o.tick = 1'b1;
        seen_d          = 1'b0;
      end else begin
        priority if (pos_q == PosHunt) begin
          if (rx_byte_i == start_q) begin
            pos_d = PosFirst;
          end
        end else if (pos_q != PosLast) begin
          pos_d    = pos_q + 5'd1;
          store_we = (pos_q <= PosStoreEnd);
        end else begin
          pos_d = PosHunt;
          if (rx_byte_i == end_q) begin
            push_o = 1'b1;
            seen_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosHunt;
      seen_q  <= 1'b0;
      start_q <= StartByteRst;
      end_q   <= EndByteRst;
    end else begin
      pos_q  <= pos_d;
      seen_q <= seen_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_START_BYTE) begin
          start_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_END_BYTE) begin
          end_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      frame_q[wr_idx] <= rx_byte_i;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosLast)
    else $error("frame position out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("job pushed into full queue");

  a_seen_on_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && !push_job_o.tick) |=> seen_q)
    else $error("good frame not recorded for link status");

endmodule

`default_nettype wire

@@ hdl/btafd_queue.sv @@
// ----------------------------------------------------------------------------
// btafd_queue
// Small job queue between the framing front and the decode back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btafd_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire btafd_pkg::job_t push_job_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output btafd_pkg::job_t      head_o,
  output logic                 empty_o
);
  import btafd_pkg::*;

  job_t             entry_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entry_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= push_job_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue count overflow");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o || full_o) |-> (wr_q == rd_q))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

@@ hdl/btafd_back.sv @@
// ----------------------------------------------------------------------------
// btafd_back
// Result issue and decode pipeline: date fields, milliseconds and angles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btafd_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire btafd_pkg::job_t head_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [1:0]           result_kind_o,
  output logic                 last_o,
  output logic [11:0]          year_o,
  output logic [4:0]           month_o,
  output logic [5:0]           day_o,
  output logic [5:0]           hour_o,
  output logic [6:0]           minute_o,
  output logic [6:0]           second_o,
  output logic [12:0]          millisecond_o,
  output logic [11:0]          degree_o,
  output logic [5:0]           arcminute_o,
  output logic [5:0]           arcsecond_o
);
  import btafd_pkg::*;

  // arcseconds = code * 1296000 / 2^29 = code * 10125 / 2^22
  localparam logic [13:0] AngScale  = 14'd10125;
  localparam int unsigned AngShift  = 22;
  localparam logic [24:0] Recip60   = 25'd17895697;
  localparam int unsigned RecipSh   = 30;
  localparam logic [15:0] Recip10   = 16'd52429;
  localparam int unsigned Recip10Sh = 19;
  localparam logic [11:0] YearBase  = 12'd2000;

  typedef struct packed {
    kind_e       kind;
    logic        last;
    logic [11:0] year;
    logic [4:0]  month;
    logic [5:0]  day;
    logic [5:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [12:0] ms;
  } info_t;

  logic                       en, issue, elev_q, elev_d;
  logic [FrameBytes-1:0][7:0] f;
  logic [31:0]                code;
  logic [45:0]                ang_prod;
  logic [31:0]                ms_prod;
  info_t                      info0;

  logic        v1_q, v2_q, v3_q, v4_q, v5_q;
  info_t       i1_q, i2_q, i3_q, i4_q, i5_q;
  logic [23:0] t1_q, t2_q;
  logic [17:0] qa2_q, q3_q, q4_q;
  logic [5:0]  sec3_q, sec4_q, sec5_q;
  logic [11:0] qb4_q, deg5_q;
  logic [5:0]  min5_q;

  logic [48:0] p2;
  logic [23:0] r3;
  logic        ge3;
  logic [42:0] p4;
  logic [17:0] r5;
  logic        ge5;

  assign en    = !v5_q || out_ready_i;
  assign issue = en && !empty_i;
  assign f     = head_i.tick ? '0 : head_i.frame;

  always_comb begin
    pop_o      = 1'b0;
    elev_d     = elev_q;
    info0.kind = KIND_AZIMUTH;
    info0.last = 1'b0;
    if (issue) begin
      priority if (head_i.tick) begin
        info0.kind = head_i.link_ok ? KIND_LINK_OK : KIND_LINK_LOST;
        info0.last = 1'b1;
        pop_o      = 1'b1;
      end else if (!elev_q) begin
        elev_d = 1'b1;
      end else begin
        info0.kind = KIND_ELEVATION;
        info0.last = 1'b1;
        pop_o      = 1'b1;
        elev_d     = 1'b0;
      end
    end
    code = elev_q ? {f[15], f[14], f[13], f[12]} : {f[11], f[10], f[9], f[8]};
    info0.year   = head_i.tick ? '0
                 : YearBase + 12'(f[0][7:4]) * 12'd10 + 12'(f[0][3:0]);
    info0.month  = 5'(f[1][4]) * 5'd10 + 5'(f[1][3:0]);
    info0.day    = 6'(f[2][5]) * 6'd20 + 6'(f[2][4]) * 6'd10 + 6'(f[2][3:0]);
    info0.hour   = 6'(f[3][5]) * 6'd20 + 6'(f[3][4]) * 6'd10 + 6'(f[3][3:0]);
    info0.minute = 7'(f[4][6]) * 7'd40 + 7'(f[4][5]) * 7'd20 + 7'(f[4][4]) * 7'd10
                 + 7'(f[4][3:0]);
    info0.second = 7'(f[5][6]) * 7'd40 + 7'(f[5][5]) * 7'd20 + 7'(f[5][4]) * 7'd10
                 + 7'(f[5][3:0]);
    ms_prod      = 32'({f[7], f[6]}) * 32'(Recip10);
    info0.ms     = ms_prod[31:Recip10Sh];
    ang_prod     = 46'(code) * 46'(AngScale);
  end

  // seconds split
  assign p2  = 49'(t1_q) * 49'(Recip60);
  assign r3  = t2_q - 24'(qa2_q) * 24'd60;
  assign ge3 = (r3 >= 24'd60);
  // degree split
  assign p4  = 43'(q3_q) * 43'(Recip60);
  assign r5  = q4_q - 18'(qb4_q) * 18'd60;
  assign ge5 = (r5 >= 18'd60);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elev_q <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
    end else begin
      elev_q <= elev_d;
      if (en) begin
        v1_q <= issue;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
        v5_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      i1_q   <= info0;
      t1_q   <= ang_prod[AngShift+23:AngShift];
      i2_q   <= i1_q;
      t2_q   <= t1_q;
      qa2_q  <= p2[RecipSh+17:RecipSh];
      i3_q   <= i2_q;
      q3_q   <= ge3 ? qa2_q + 18'd1 : qa2_q;
      sec3_q <= ge3 ? 6'(r3 - 24'd60) : 6'(r3);
      i4_q   <= i3_q;
      q4_q   <= q3_q;
      sec4_q <= sec3_q;
      qb4_q  <= p4[RecipSh+11:RecipSh];
      i5_q   <= i4_q;
      sec5_q <= sec4_q;
      deg5_q <= ge5 ? qb4_q + 12'd1 : qb4_q;
      min5_q <= ge5 ? 6'(r5 - 18'd60) : 6'(r5);
    end
  end

  assign out_valid_o   = v5_q;
  assign result_kind_o = i5_q.kind;
  assign last_o        = i5_q.last;
  assign year_o        = i5_q.year;
  assign month_o       = i5_q.month;
  assign day_o         = i5_q.day;
  assign hour_o        = i5_q.hour;
  assign minute_o      = i5_q.minute;
  assign second_o      = i5_q.second;
  assign millisecond_o = i5_q.ms;
  assign degree_o      = deg5_q;
  assign arcminute_o   = min5_q;
  assign arcsecond_o   = sec5_q;

  a_elev_has_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    elev_q |-> (!empty_i && !head_i.tick))
    else $error("elevation pending without frame job");

  a_sub_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> (sec5_q < 6'd60 && min5_q < 6'd60))
    else $error("arcminute or arcsecond out of range");

  a_tick_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && (i5_q.kind == KIND_LINK_OK || i5_q.kind == KIND_LINK_LOST))
      |-> (deg5_q == '0 && min5_q == '0 && sec5_q == '0 && i5_q.year == '0))
    else $error("tick result carries nonzero fields");

endmodule

`default_nettype wire

@@ hdl/bcd_time_angle_frame_decoder_top.sv @@
// ----------------------------------------------------------------------------
// bcd_time_angle_frame_decoder_top
// Frames serial bytes, decodes BCD time and two angle codes, reports link.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  in       | input     | in_valid_i / in_ready_o   | opcode_i, rx_byte_i
//  out      | output    | out_valid_o / out_ready_i | result_kind_o .. arcsecond_o
//  cfg      | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  one input transfer per cycle; the 2-entry job queue sets back pressure
//  a good frame issues two results into the decode pipe (azimuth, elevation)
//  issued results pass through the registered decode pipe to the outputs
//  an output stall freezes the whole decode pipe; the front frames until the queue fills
//  reset clears framing state, link flag, queue and pipe valid bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcd_time_angle_frame_decoder_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          opcode_i,
  input  wire logic [7:0]                    rx_byte_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [btafd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]                    cfg_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         result_kind_o,
  output logic                               last_o,
  output logic [11:0]                        year_o,
  output logic [4:0]                         month_o,
  output logic [5:0]                         day_o,
  output logic [5:0]                         hour_o,
  output logic [6:0]                         minute_o,
  output logic [6:0]                         second_o,
  output logic [12:0]                        millisecond_o,
  output logic [11:0]                        degree_o,
  output logic [5:0]                         arcminute_o,
  output logic [5:0]                         arcsecond_o
);
  import btafd_pkg::*;

  logic push, full, pop, empty;
  job_t push_job, head;

  btafd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .rx_byte_i   (rx_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .push_job_o  (push_job),
    .full_i      (full)
  );

  btafd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty)
  );

  btafd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .last_o        (last_o),
    .year_o        (year_o),
    .month_o       (month_o),
    .day_o         (day_o),
    .hour_o        (hour_o),
    .minute_o      (minute_o),
    .second_o      (second_o),
    .millisecond_o (millisecond_o),
    .degree_o      (degree_o),
    .arcminute_o   (arcminute_o),
    .arcsecond_o   (arcsecond_o)
  );

endmodule

`default_nettype wire

@@ sim/bcd_time_angle_frame_decoder_top_tb.sv @@
// ----------------------------------------------------------------------------
// bcd_time_angle_frame_decoder_top_tb
// Sends serial bytes and one-second ticks, some inside and some outside
// frames, to the frame decoder. A scoreboard tracks framing and link state,
// decodes each good frame into azimuth and elevation results and checks
// every output transfer field by field. Start and end bytes are changed
// between phases while sender gaps and receiver stalls vary.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcd_time_angle_frame_decoder_top_tb;
  import btafd_pkg::*;

  localparam int unsigned HalfPeriod   = 10;
  localparam int unsigned ResetCycles  = 9;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned StallLimit   = 4000;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    kind_e       kind;
    logic        last;
    logic [11:0] year;
    logic [4:0]  month;
    logic [5:0]  day;
    logic [5:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [12:0] millisecond;
    logic [11:0] degree;
    logic [5:0]  arcminute;
    logic [5:0]  arcsecond;
  } decoded_result_t;

  class frame_scoreboard;
    localparam int unsigned FrameLen      = 20;
    localparam int unsigned YearBase      = 2000;
    localparam int unsigned AzimuthBase   = 9;
    localparam int unsigned ElevationBase = 13;
    localparam longint unsigned ArcsecPerTurn = 1296000;
    localparam int unsigned CodeShift     = 29;

    logic [7:0]      start_byte;
    logic [7:0]      end_byte;
    logic [4:0]      byte_pos;
    logic [7:0]      frame_bytes [FrameLen-1];
    bit              link_seen;
    decoded_result_t pending_decodes [$];
    int unsigned     errors;

    function new();
      start_byte = StartByteRst;
      end_byte   = EndByteRst;
      byte_pos   = PosHunt;
      link_seen  = 1'b0;
      errors     = 0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [7:0] value);
      case (idx)
        CFG_START_BYTE: start_byte = value;
        CFG_END_BYTE:   end_byte = value;
        default: ;
      endcase
    endfunction

    function decoded_result_t decode_angle(kind_e kind, logic last_flag, int unsigned base);
      decoded_result_t r;
      logic [31:0] code;
      longint unsigned total_sec;
      code = {frame_bytes[base+3], frame_bytes[base+2], frame_bytes[base+1], frame_bytes[base]};
      total_sec = (64'(code) * ArcsecPerTurn) >> CodeShift;
      r.kind   = kind;
      r.last   = last_flag;
      r.year   = 12'(YearBase + 10 * frame_bytes[1][7:4] + frame_bytes[1][3:0]);
      r.month  = 5'(10 * frame_bytes[2][4] + frame_bytes[2][3:0]);
      r.day    = 6'(20 * frame_bytes[3][5] + 10 * frame_bytes[3][4] + frame_bytes[3][3:0]);
      r.hour   = 6'(20 * frame_bytes[4][5] + 10 * frame_bytes[4][4] + frame_bytes[4][3:0]);
      r.minute = 7'(40 * frame_bytes[5][6] + 20 * frame_bytes[5][5] + 10 * frame_bytes[5][4]
                    + frame_bytes[5][3:0]);
      r.second = 7'(40 * frame_bytes[6][6] + 20 * frame_bytes[6][5] + 10 * frame_bytes[6][4]
                    + frame_bytes[6][3:0]);
      r.millisecond = 13'({frame_bytes[8], frame_bytes[7]} / 16'd10);
      r.degree    = 12'(total_sec / 3600);
      r.arcminute = 6'((total_sec / 60) % 60);
      r.arcsecond = 6'(total_sec % 60);
      return r;
    endfunction

    function void note_transfer(op_e op, logic [7:0] value);
      decoded_result_t r;
      if (op == OP_TICK) begin
        r = '0;
        r.kind = link_seen ? KIND_LINK_OK : KIND_LINK_LOST;
        r.last = 1'b1;
        pending_decodes.push_back(r);
        link_seen = 1'b0;
      end else if (byte_pos == PosHunt) begin
        if (value == start_byte) begin
          frame_bytes[0] = value;
          byte_pos = PosFirst;
        end
      end else if (byte_pos < PosLast) begin
        frame_bytes[byte_pos] = value;
        byte_pos = byte_pos + 5'd1;
      end else begin
        byte_pos = PosHunt;
        if (value == end_byte) begin
          link_seen = 1'b1;
          pending_decodes.push_back(decode_angle(KIND_AZIMUTH, 1'b0, AzimuthBase));
          pending_decodes.push_back(decode_angle(KIND_ELEVATION, 1'b1, ElevationBase));
        end
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      end
    endfunction

    function void check_output(decoded_result_t seen);
      decoded_result_t want;
      if (pending_decodes.size() == 0) begin
        errors++;
        $display("%0t: result with none pending, kind %0d", $time, seen.kind);
        return;
      end
      want = pending_decodes.pop_front();
      compare_field("result_kind", want.kind, seen.kind);
      compare_field("last", want.last, seen.last);
      compare_field("year", want.year, seen.year);
      compare_field("month", want.month, seen.month);
      compare_field("day", want.day, seen.day);
      compare_field("hour", want.hour, seen.hour);
      compare_field("minute", want.minute, seen.minute);
      compare_field("second", want.second, seen.second);
      compare_field("millisecond", want.millisecond, seen.millisecond);
      compare_field("degree", want.degree, seen.degree);
      compare_field("arcminute", want.arcminute, seen.arcminute);
      compare_field("arcsecond", want.arcsecond, seen.arcsecond);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               opcode;
  logic [7:0]         rx_byte;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [7:0]         cfg_data;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         result_kind;
  logic               last;
  logic [11:0]        year;
  logic [4:0]         month;
  logic [5:0]         day;
  logic [5:0]         hour;
  logic [6:0]         minute;
  logic [6:0]         second;
  logic [12:0]        millisecond;
  logic [11:0]        degree;
  logic [5:0]         arcminute;
  logic [5:0]         arcsecond;

  decoded_result_t seen_result;
  frame_scoreboard sb = new();
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  bit              hold_output;
  int unsigned     quiet_cycles;

  assign seen_result = {result_kind, last, year, month, day, hour, minute, second,
                        millisecond, degree, arcminute, arcsecond};

  bcd_time_angle_frame_decoder_top i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .opcode_i      (opcode),
    .rx_byte_i     (rx_byte),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .result_kind_o (result_kind),
    .last_o        (last),
    .year_o        (year),
    .month_o       (month),
    .day_o         (day),
    .hour_o        (hour),
    .minute_o      (minute),
    .second_o      (second),
    .millisecond_o (millisecond),
    .degree_o      (degree),
    .arcminute_o   (arcminute),
    .arcsecond_o   (arcsecond)
  );

  always begin
    #HalfPeriod clk = 1'b1;
    #HalfPeriod clk = 1'b0;
  end

  // receiver with random stalls and one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_output = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_output(seen_result);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input op_e op, input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    rx_byte  <= value;
    do @(posedge clk); while (!in_ready);
    sb.note_transfer(op, value);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, value);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_decodes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [7:0] start_value, input logic [7:0] end_value);
    wait_drained();
    write_register($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 8'($urandom));
    write_register(CFG_START_BYTE, start_value);
    write_register(CFG_END_BYTE, end_value);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] frame_data_byte();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) return sb.start_byte;
    if (pick < 10) return 8'h00;
    if (pick < 15) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic send_directed();
    logic [7:0] frame [20];
    send_item(OP_TICK, 8'hFF);
    frame[0] = sb.start_byte;
    for (int i = 1; i <= 12; i++) frame[i] = 8'hFF;
    for (int i = 13; i <= 16; i++) frame[i] = 8'h00;
    frame[17] = sb.start_byte;
    frame[18] = 8'h00;
    frame[19] = sb.end_byte;
    for (int i = 0; i < 20; i++) begin
      if (i == 13) send_item(OP_TICK, 8'h00);
      send_item(OP_BYTE, frame[i]);
    end
    send_item(OP_TICK, 8'h5A);
    send_item(OP_TICK, 8'hA5);
  endtask

  task automatic send_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    logic [7:0]  frame [20];
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_item(OP_TICK, 8'($urandom));
        sent++;
      end else if (pick < 18) begin
        repeat ($urandom_range(1, 3)) send_item(OP_BYTE, 8'($urandom));
      end else begin
        frame[0] = sb.start_byte;
        for (int i = 1; i < 19; i++) frame[i] = frame_data_byte();
        frame[19] = ($urandom_range(99) < 85) ? sb.end_byte : 8'($urandom);
        for (int i = 0; i < 20; i++) begin
          if (i > 0 && $urandom_range(99) < 4) begin
            send_item(OP_TICK, 8'($urandom));
            sent++;
          end
          send_item(OP_BYTE, frame[i]);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    opcode    <= OP_BYTE;
    rx_byte   <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_START_BYTE;
    cfg_data  <= 8'h00;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_output    = 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values, no idling
    reconfigure(StartByteRst, EndByteRst);
    send_directed();
    send_random(250);

    // extreme framing bytes, sender gaps
    reconfigure(8'h00, 8'hFF);
    send_idle_pct = 52;
    send_random(280);

    // swapped extremes, receiver stalls plus one long hold-off
    reconfigure(8'hFF, 8'h00);
    send_idle_pct  = 0;
    recv_stall_pct = 52;
    hold_output    = 1'b1;
    send_random(280);

    // random framing bytes, both sides idle
    reconfigure(8'($urandom), 8'($urandom));
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    send_random(280);

    wait_drained();
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
